@@ hdl/battery_charge_discharge_rotation_macros.svh @@
// Assertion macros shared by the rotation controller RTL.
// Needs no package; each macro takes clock, reset and the checked terms.
`ifndef BATTERY_CHARGE_DISCHARGE_ROTATION_MACROS_SVH
`define BATTERY_CHARGE_DISCHARGE_ROTATION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BCDR_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCDR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/bcdr_pkg.sv @@
// Shared types and constants of the battery rotation controller.
// No dependencies; every design module uses it by scoped names.
package bcdr_pkg;

  localparam int NUM_VOLTS = 5;
  localparam int MV_W      = 16;
  localparam int TICK_W    = 32;
  localparam int IDX_W     = 3;
  localparam int BAD_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [MV_W-1:0]  PRESENT_MV    = 16'd2500;
  localparam logic [BAD_W-1:0] DIS_BAD_LIMIT = 8'd5;
  localparam logic [BAD_W-1:0] CHG_BAD_LIMIT = 8'd10;
  localparam logic [BAD_W-1:0] BAD_SAT       = 8'd255;

  localparam logic [MV_W-1:0]   RST_MAX_CHARGE_MV    = 16'd4200;
  localparam logic [MV_W-1:0]   RST_MIN_DISCHARGE_MV = 16'd3300;
  localparam logic [TICK_W-1:0] RST_CHARGE_INTERVAL  = 32'd60000;
  localparam logic [TICK_W-1:0] RST_DIS_INTERVAL     = 32'd60000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_CHARGE_MV      = 2'd0,
    REG_MIN_DISCHARGE_MV   = 2'd1,
    REG_CHARGE_INTERVAL    = 2'd2,
    REG_DISCHARGE_INTERVAL = 2'd3
  } cfg_reg_e;

  typedef logic [NUM_VOLTS-1:0][MV_W-1:0] volt_vec_t;

  typedef struct packed {
    logic [TICK_W-1:0] now_tick;
    logic [MV_W-1:0]   volt_0;
    logic [MV_W-1:0]   volt_1;
    logic [MV_W-1:0]   volt_2;
    logic [MV_W-1:0]   volt_3;
    logic [MV_W-1:0]   volt_4;
    logic [1:0]        backup_index;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]     discharge_target;
    logic                 discharge_found;
    logic [IDX_W-1:0]     charge_target;
    logic                 charge_found;
    logic [NUM_VOLTS-1:0] present_mask;
  } out_beat_t;

  // Per-battery flags from one lane.
  typedef struct packed {
    logic present;
    logic dis_ok;    // present and above the discharge floor
    logic chg_ok;    // present and below the charge ceiling
    logic dis_low;   // at or below the discharge floor
    logic chg_high;  // at or above the charge ceiling
  } lane_t;

  // Selection or hold result of one side.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

endpackage

@@ hdl/bcdr_lane.sv @@
// One battery lane: threshold compares on a single voltage.
// Depends on bcdr_pkg.
module bcdr_lane (
  input  logic [bcdr_pkg::MV_W-1:0] volt,
  input  logic [bcdr_pkg::MV_W-1:0] max_charge_mv,
  input  logic [bcdr_pkg::MV_W-1:0] min_discharge_mv,
  output bcdr_pkg::lane_t           flags
);

  always_comb begin
    flags.present  = (volt >= bcdr_pkg::PRESENT_MV);
    flags.dis_ok   = flags.present && (volt > min_discharge_mv);
    flags.chg_ok   = flags.present && (volt < max_charge_mv);
    flags.dis_low  = (volt <= min_discharge_mv);
    flags.chg_high = (volt >= max_charge_mv);
  end

endmodule

@@ hdl/bcdr_pick.sv @@
// Merge stage: picks the highest (or lowest) eligible lane voltage.
// Ties go to the lowest index. Depends on bcdr_pkg.
module bcdr_pick #(
  parameter int NUM    = 4,
  parameter bit IS_MIN = 1'b0
) (
  input  bcdr_pkg::volt_vec_t                volts,
  input  logic [bcdr_pkg::NUM_VOLTS-1:0]     elig,
  output bcdr_pkg::pick_t                    pick
);

  logic [bcdr_pkg::MV_W-1:0] best;

  always_comb begin
    pick = '0;
    best = '0;
    for (int i = 0; i < NUM; i++) begin
      if (elig[i] && (!pick.found ||
          (IS_MIN ? (volts[i] < best) : (volts[i] > best)))) begin
        pick.found = 1'b1;
        pick.idx   = bcdr_pkg::IDX_W'(i);
        best       = volts[i];
      end
    end
  end

endmodule

@@ hdl/bcdr_side.sv @@
// One rotation side (charge or discharge): hold state, interval and
// bad-reading tracking, and the idle search. Depends on bcdr_pkg, bcdr_pick.
`include "battery_charge_discharge_rotation_macros.svh"
module bcdr_side #(
  parameter int NUM_SEARCH = 4,
  parameter bit IS_CHARGE  = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic [bcdr_pkg::TICK_W-1:0]        now_tick,
  input  logic [bcdr_pkg::TICK_W-1:0]        interval,
  input  bcdr_pkg::volt_vec_t                volts,
  input  logic [bcdr_pkg::NUM_VOLTS-1:0]     qual,
  input  logic [bcdr_pkg::NUM_VOLTS-1:0]     bad,
  output bcdr_pkg::pick_t                    res
);

  localparam logic [bcdr_pkg::BAD_W-1:0] BAD_LIMIT =
    IS_CHARGE ? bcdr_pkg::CHG_BAD_LIMIT : bcdr_pkg::DIS_BAD_LIMIT;

  logic                          active_r, active_nxt;
  logic [bcdr_pkg::TICK_W-1:0]   start_r, start_nxt;
  logic [bcdr_pkg::IDX_W-1:0]    cur_r, cur_nxt;
  logic [bcdr_pkg::IDX_W-1:0]    prev_r, prev_nxt;
  logic [bcdr_pkg::BAD_W-1:0]    bad_r, bad_nxt;

  logic [bcdr_pkg::NUM_VOLTS-1:0] elig;
  logic [bcdr_pkg::TICK_W-1:0]    elapsed;
  logic [bcdr_pkg::BAD_W-1:0]     bad_inc;
  bcdr_pkg::pick_t                pick;
  bcdr_pkg::pick_t                sel;

  // Exclude the battery used last from the first search.
  assign elig = qual & ~(bcdr_pkg::NUM_VOLTS'(1) << prev_r);

  bcdr_pick #(
    .NUM    (NUM_SEARCH),
    .IS_MIN (IS_CHARGE)
  ) u_pick (
    .volts (volts),
    .elig  (elig),
    .pick  (pick)
  );

  assign elapsed = now_tick - start_r;
  assign bad_inc = (bad_r == bcdr_pkg::BAD_SAT) ? bcdr_pkg::BAD_SAT
                                                 : bad_r + bcdr_pkg::BAD_W'(1);

  // Discharge falls back to the last battery when it alone qualifies.
  always_comb begin
    sel = pick;
    if (!IS_CHARGE && !pick.found && qual[prev_r]) begin
      sel.found = 1'b1;
      sel.idx   = prev_r;
    end
  end

  always_comb begin
    active_nxt = active_r;
    start_nxt  = start_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    bad_nxt    = bad_r;
    if (!active_r) begin
      res = sel;
      if (sel.found) begin
        active_nxt = 1'b1;
        start_nxt  = now_tick;
        cur_nxt    = sel.idx;
      end
    end else begin
      res.found = 1'b1;
      res.idx   = cur_r;
      if (elapsed >= interval) begin
        prev_nxt   = cur_r;
        active_nxt = 1'b0;
      end else if (bad[cur_r]) begin
        bad_nxt = bad_inc;
        if (bad_inc >= BAD_LIMIT) begin
          prev_nxt   = cur_r;
          active_nxt = 1'b0;
        end
      end else begin
        bad_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      start_r  <= '0;
      cur_r    <= '0;
      prev_r   <= '0;
      bad_r    <= '0;
    end else if (advance) begin
      active_r <= active_nxt;
      start_r  <= start_nxt;
      cur_r    <= cur_nxt;
      prev_r   <= prev_nxt;
      bad_r    <= bad_nxt;
    end
  end

  `BCDR_ASSERT_SAME(a_cur_in_range, clk, rst_n, active_r, cur_r < NUM_SEARCH, "held battery outside search range")
  `BCDR_ASSERT_SAME(a_prev_in_range, clk, rst_n, 1'b1, prev_r < NUM_SEARCH, "last battery outside search range")
  `BCDR_ASSERT_NEXT(a_bad_limit_release, clk, rst_n, advance && active_r && bad[cur_r] && (bad_inc >= BAD_LIMIT), !active_r, "bad-reading limit did not release the battery")

endmodule

@@ hdl/battery_charge_discharge_rotation.sv @@
// Battery charge/discharge rotation controller, top level.
// Depends on bcdr_pkg, bcdr_lane, bcdr_pick, bcdr_side.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): one beat per poll, carrying
//   the time stamp, five battery voltages and the backup index.
//   Result channel (out_valid/out_stall/out_data): one beat per poll with
//   the discharge and charge targets, their found flags and the present mask.
//   Config port (cfg_we/cfg_index/cfg_wdata): single-cycle register writes,
//   no read-back; write only while no poll is in flight.
// Output: an accepted poll's result is registered, not driven combinationally.
// Throughput: one poll per cycle while in_stall is low. Five lane comparators
//   and one merge per side settle within the accept cycle; both sides update
//   their hold state on that same edge, so the next poll can follow at once.
// Stall: results go to an output register backed by one skid entry. While
//   the receiver stalls, a second poll is still taken into the skid entry;
//   in_stall rises only once the skid entry holds a beat.
// Reset (rst_n low, synchronous): both sides go idle with battery 0 as the
//   last battery, bad counts clear, config registers return to their defaults
//   and both output entries empty.
`include "battery_charge_discharge_rotation_macros.svh"
module battery_charge_discharge_rotation #(
  parameter int MAIN_BATTERIES         = 4,
  parameter int EXTRA_CHARGE_BATTERIES = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bcdr_pkg::in_beat_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output bcdr_pkg::out_beat_t                 out_data,
  // configuration port
  input  logic                                cfg_we,
  input  logic [bcdr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcdr_pkg::CFG_W-1:0]          cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bcdr_pkg::MV_W-1:0]   max_charge_mv_r;
  logic [bcdr_pkg::MV_W-1:0]   min_discharge_mv_r;
  logic [bcdr_pkg::TICK_W-1:0] charge_interval_r;
  logic [bcdr_pkg::TICK_W-1:0] discharge_interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_charge_mv_r      <= bcdr_pkg::RST_MAX_CHARGE_MV;
      min_discharge_mv_r   <= bcdr_pkg::RST_MIN_DISCHARGE_MV;
      charge_interval_r    <= bcdr_pkg::RST_CHARGE_INTERVAL;
      discharge_interval_r <= bcdr_pkg::RST_DIS_INTERVAL;
    end else if (cfg_we) begin
      case (bcdr_pkg::cfg_reg_e'(cfg_index))
        bcdr_pkg::REG_MAX_CHARGE_MV:      max_charge_mv_r      <= cfg_wdata[bcdr_pkg::MV_W-1:0];
        bcdr_pkg::REG_MIN_DISCHARGE_MV:   min_discharge_mv_r   <= cfg_wdata[bcdr_pkg::MV_W-1:0];
        bcdr_pkg::REG_CHARGE_INTERVAL:    charge_interval_r    <= cfg_wdata;
        bcdr_pkg::REG_DISCHARGE_INTERVAL: discharge_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic                skid_valid_r;
  logic                out_valid_r;
  bcdr_pkg::out_beat_t out_data_r;
  bcdr_pkg::out_beat_t skid_data_r;
  logic                in_acc;
  logic                out_take;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Lanes: one comparator set per battery
  // ---------------------------------------------------------------------------
  bcdr_pkg::volt_vec_t              volts;
  bcdr_pkg::lane_t                  lane_flags [bcdr_pkg::NUM_VOLTS];
  logic [bcdr_pkg::NUM_VOLTS-1:0]   present_mask;
  logic [bcdr_pkg::NUM_VOLTS-1:0]   dis_qual;
  logic [bcdr_pkg::NUM_VOLTS-1:0]   chg_qual;
  logic [bcdr_pkg::NUM_VOLTS-1:0]   dis_bad;
  logic [bcdr_pkg::NUM_VOLTS-1:0]   chg_bad;

  assign volts = {in_data.volt_4, in_data.volt_3, in_data.volt_2,
                  in_data.volt_1, in_data.volt_0};

  for (genvar g = 0; g < bcdr_pkg::NUM_VOLTS; g++) begin : g_lane
    bcdr_lane u_lane (
      .volt             (volts[g]),
      .max_charge_mv    (max_charge_mv_r),
      .min_discharge_mv (min_discharge_mv_r),
      .flags            (lane_flags[g])
    );
    assign present_mask[g] = lane_flags[g].present;
    assign dis_qual[g]     = lane_flags[g].dis_ok;
    assign chg_qual[g]     = lane_flags[g].chg_ok;
    assign dis_bad[g]      = lane_flags[g].dis_low;
    assign chg_bad[g]      = lane_flags[g].chg_high;
  end

  // ---------------------------------------------------------------------------
  // Sides: discharge searches the main batteries, charge adds the extras
  // ---------------------------------------------------------------------------
  bcdr_pkg::pick_t dis_res;
  bcdr_pkg::pick_t chg_res;

  bcdr_side #(
    .NUM_SEARCH (MAIN_BATTERIES),
    .IS_CHARGE  (1'b0)
  ) u_dis (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (in_acc),
    .now_tick (in_data.now_tick),
    .interval (discharge_interval_r),
    .volts    (volts),
    .qual     (dis_qual),
    .bad      (dis_bad),
    .res      (dis_res)
  );

  bcdr_side #(
    .NUM_SEARCH (MAIN_BATTERIES + EXTRA_CHARGE_BATTERIES),
    .IS_CHARGE  (1'b1)
  ) u_chg (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (in_acc),
    .now_tick (in_data.now_tick),
    .interval (charge_interval_r),
    .volts    (volts),
    .qual     (chg_qual),
    .bad      (chg_bad),
    .res      (chg_res)
  );

  // Assemble the result beat; a failed discharge search points at the backup.
  bcdr_pkg::out_beat_t res_beat;

  always_comb begin
    res_beat.discharge_found  = dis_res.found;
    res_beat.discharge_target = dis_res.found ? dis_res.idx
                              : bcdr_pkg::IDX_W'(MAIN_BATTERIES)
                                + {1'b0, in_data.backup_index};
    res_beat.charge_found     = chg_res.found;
    res_beat.charge_target    = chg_res.found ? chg_res.idx
                                              : bcdr_pkg::IDX_W'(MAIN_BATTERIES);
    res_beat.present_mask     = present_mask;
  end

  // ---------------------------------------------------------------------------
  // Output register and skid entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // Drain the skid entry into the output once the receiver takes a beat.
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= res_beat;
      end else begin
        skid_data_r <= res_beat;
      end
    end
  end

  `BCDR_ASSERT_SAME(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r, "skid entry full while output register empty")
  `BCDR_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_r && out_stall, skid_valid_r && out_valid_r, "skid entry lost under stall")
  `BCDR_ASSERT_NEXT(a_accept_shows, clk, rst_n, in_acc && !out_valid_r, out_valid_r && !skid_valid_r, "accepted poll did not reach the output register")

endmodule
